// File: rtl/tgm_pkg.sv
// shared types, register indexes and reset values of the tilt gesture unit
`default_nettype none

package tgm_pkg;

   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned COUNT_W     = 4;

   localparam logic [14:0] MOVE_DEAD_ZONE_RST      = 15'd410;
   localparam logic [14:0] CLICK_THRESHOLD_RST     = 15'd2048;
   localparam logic [7:0]  X_GAIN_RST              = 8'd30;
   localparam logic [7:0]  Y_GAIN_RST              = 8'd60;
   localparam logic signed [15:0] ALT_ANGLE_THR_RST = 16'sd5120;
   localparam logic signed [15:0] ALT_RATE_THR_RST  = 16'sd1280;
   localparam logic [15:0] ZOOM_WINDOW_TICKS_RST   = 16'd1500;

   localparam logic [COUNT_W-1:0] CLICK_COUNT_MAX  = 4'd15;
   localparam logic [COUNT_W-1:0] ZOOM_IN_CLICKS   = 4'd3;
   localparam logic [COUNT_W-1:0] ZOOM_OUT_CLICKS  = 4'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MOVE_DEAD_ZONE    = 3'd0,
      CSR_CLICK_THRESHOLD   = 3'd1,
      CSR_X_GAIN            = 3'd2,
      CSR_Y_GAIN            = 3'd3,
      CSR_ALT_ANGLE_THR     = 3'd4,
      CSR_ALT_RATE_THR      = 3'd5,
      CSR_ZOOM_WINDOW_TICKS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [14:0]        move_dead_zone;
      logic [14:0]        click_threshold;
      logic [7:0]         x_gain;
      logic [7:0]         y_gain;
      logic signed [15:0] alt_angle_threshold;
      logic signed [15:0] alt_rate_threshold;
      logic [15:0]        zoom_window_ticks;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] tilt1_x;
      logic signed [15:0] tilt1_y;
      logic signed [15:0] tilt2_x;
      logic signed [15:0] angle1_y;
      logic signed [15:0] angle2_y;
      logic signed [15:0] rate1_x;
      logic signed [15:0] rate2_x;
   } req_type;

   typedef struct packed {
      logic              move_valid;
      logic signed [7:0] move_dx;
      logic signed [7:0] move_dy;
      logic              right_click;
      logic              left_click;
      logic              alt_tab;
      logic              zoom_in;
      logic              zoom_out;
      logic              release_buttons;
   } rsp_type;

   typedef struct packed {
      logic move_valid;
      logic signed [7:0] move_dx;
      logic signed [7:0] move_dy;
   } move_type;

   typedef struct packed {
      logic right_click;
      logic left_click;
      logic alt_tab;
      logic zoom_in;
      logic zoom_out;
      logic release_buttons;
   } gest_type;

endpackage

`default_nettype wire

// File: rtl/tgm_cursor.sv
// cursor deltas from sensor 1 tilt: dead zone, gain, truncation and saturation
`default_nettype none

module tgm_cursor (
   input  tgm_pkg::req_type  item,
   input  tgm_pkg::cfg_type  cfg,
   output tgm_pkg::move_type move
);
   import tgm_pkg::*;

   function automatic logic [16:0] magnitude(input logic signed [15:0] a);
      logic [16:0] ext;
      ext = {a[15], a};
      return a[15] ? (17'd0 - ext) : ext;
   endfunction

   function automatic logic signed [7:0] scale(input logic signed [15:0] a,
                                                input logic [7:0] gain,
                                                input logic negate);
      logic signed [24:0] prod;
      logic signed [24:0] biased;
      logic signed [12:0] quot;
      logic signed [13:0] val;
      logic signed [7:0]  res;
      prod   = a * $signed({1'b0, gain});
      biased = prod + (prod[24] ? 25'sd4095 : 25'sd0);
      quot   = 13'(biased >>> 12);
      val    = negate ? -14'(quot) : 14'(quot);
      if (val > 14'sd127) begin
         res = 8'sd127;
      end else if (val < -14'sd127) begin
         res = -8'sd127;
      end else begin
         res = 8'(val);
      end
      return res;
   endfunction

   logic x_on;
   logic y_on;

   assign x_on = magnitude(item.tilt1_x) > {2'b00, cfg.move_dead_zone};
   assign y_on = magnitude(item.tilt1_y) > {2'b00, cfg.move_dead_zone};

   assign move.move_valid = x_on || y_on;
   assign move.move_dx    = y_on ? scale(item.tilt1_y, cfg.x_gain, 1'b0) : 8'sd0;
   assign move.move_dy    = x_on ? scale(item.tilt1_x, cfg.y_gain, 1'b1) : 8'sd0;

endmodule

`default_nettype wire

// File: rtl/tgm_gesture.sv
// click hold state, left click counting, zoom window and alt-tab test
`default_nettype none

module tgm_gesture (
   input  wire               clock,
   input  wire               reset,
   input  wire               step,
   input  tgm_pkg::req_type  item,
   input  tgm_pkg::cfg_type  cfg,
   output tgm_pkg::gest_type gest
);
   import tgm_pkg::*;

   logic               right_held_ff, right_held_in;
   logic               left_held_ff, left_held_in;
   logic [COUNT_W-1:0] click_count_ff, click_count_in;
   logic               window_active_ff, window_active_in;
   logic [15:0]        window_timer_ff, window_timer_in;

   logic signed [16:0] t2x;
   logic signed [16:0] ct_pos;
   logic signed [16:0] ct_neg;

   assign t2x    = 17'(item.tilt2_x);
   assign ct_pos = $signed({2'b00, cfg.click_threshold});
   assign ct_neg = -ct_pos;

   always_comb begin
      right_held_in    = right_held_ff;
      left_held_in     = left_held_ff;
      click_count_in   = click_count_ff;
      window_active_in = window_active_ff;
      window_timer_in  = window_timer_ff;
      gest             = '0;

      if (right_held_ff) begin
         if (t2x <= ct_pos) right_held_in = 1'b0;
      end else if (left_held_ff) begin
         if (t2x >= ct_neg) begin
            left_held_in = 1'b0;
            if (click_count_ff != CLICK_COUNT_MAX) click_count_in = click_count_ff + 1'b1;
         end
      end else if (t2x > ct_pos) begin
         gest.right_click = 1'b1;
         right_held_in    = 1'b1;
      end else if (t2x < ct_neg) begin
         gest.left_click = 1'b1;
         left_held_in    = 1'b1;
      end

      gest.alt_tab = !right_held_in && !left_held_in
                     && (item.angle1_y > cfg.alt_angle_threshold)
                     && (item.angle2_y > cfg.alt_angle_threshold)
                     && (item.rate2_x > cfg.alt_rate_threshold)
                     && (item.rate1_x > cfg.alt_rate_threshold);

      if (!window_active_ff) begin
         if (click_count_in != '0) begin
            window_active_in = 1'b1;
            window_timer_in  = cfg.zoom_window_ticks;
         end
      end else if (window_timer_ff <= 16'd1) begin
         gest.zoom_in     = click_count_in == ZOOM_IN_CLICKS;
         gest.zoom_out    = click_count_in == ZOOM_OUT_CLICKS;
         click_count_in   = '0;
         window_active_in = 1'b0;
         window_timer_in  = '0;
      end else begin
         window_timer_in = window_timer_ff - 16'd1;
      end

      gest.release_buttons = (t2x < ct_pos) && (t2x > ct_neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_held_ff    <= 1'b0;
         left_held_ff     <= 1'b0;
         click_count_ff   <= '0;
         window_active_ff <= 1'b0;
         window_timer_ff  <= '0;
      end else if (step) begin
         right_held_ff    <= right_held_in;
         left_held_ff     <= left_held_in;
         click_count_ff   <= click_count_in;
         window_active_ff <= window_active_in;
         window_timer_ff  <= window_timer_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tilt_gesture_to_mouse_events_unit.sv
// top level: control registers, input register, cursor and gesture logic and result register
//
// Each accepted item is one sensor tick and gives exactly one result item. An item
// sits in the input register while the cursor and gesture logic evaluate it, and
// its result then lands in the result register. One item is accepted every cycle
// as long as results are taken; a stalled result register holds the input
// register, which in turn drops req_ready. Control registers are written through
// csr_we/csr_addr/csr_wdata; indexes beyond the last register are ignored.
`default_nettype none

module tilt_gesture_to_mouse_events_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  tgm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output tgm_pkg::rsp_type                   rsp_data,
   input  wire                                csr_we,
   input  wire [tgm_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire [tgm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tgm_pkg::*;

   cfg_type  cfg_ff;
   logic     in_valid_ff;
   req_type  in_data_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;

   logic     advance;
   move_type move;
   gest_type gest;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_dead_zone      <= MOVE_DEAD_ZONE_RST;
         cfg_ff.click_threshold     <= CLICK_THRESHOLD_RST;
         cfg_ff.x_gain              <= X_GAIN_RST;
         cfg_ff.y_gain              <= Y_GAIN_RST;
         cfg_ff.alt_angle_threshold <= ALT_ANGLE_THR_RST;
         cfg_ff.alt_rate_threshold  <= ALT_RATE_THR_RST;
         cfg_ff.zoom_window_ticks   <= ZOOM_WINDOW_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MOVE_DEAD_ZONE:    cfg_ff.move_dead_zone      <= csr_wdata[14:0];
            CSR_CLICK_THRESHOLD:   cfg_ff.click_threshold     <= csr_wdata[14:0];
            CSR_X_GAIN:            cfg_ff.x_gain              <= csr_wdata[7:0];
            CSR_Y_GAIN:            cfg_ff.y_gain              <= csr_wdata[7:0];
            CSR_ALT_ANGLE_THR:     cfg_ff.alt_angle_threshold <= $signed(csr_wdata);
            CSR_ALT_RATE_THR:      cfg_ff.alt_rate_threshold  <= $signed(csr_wdata);
            CSR_ZOOM_WINDOW_TICKS: cfg_ff.zoom_window_ticks   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) begin
         rsp_data_ff.move_valid      <= move.move_valid;
         rsp_data_ff.move_dx         <= move.move_dx;
         rsp_data_ff.move_dy         <= move.move_dy;
         rsp_data_ff.right_click     <= gest.right_click;
         rsp_data_ff.left_click      <= gest.left_click;
         rsp_data_ff.alt_tab         <= gest.alt_tab;
         rsp_data_ff.zoom_in         <= gest.zoom_in;
         rsp_data_ff.zoom_out        <= gest.zoom_out;
         rsp_data_ff.release_buttons <= gest.release_buttons;
      end
   end

   tgm_cursor u_cursor (
      .item (in_data_ff),
      .cfg  (cfg_ff),
      .move (move)
   );

   tgm_gesture u_gesture (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .cfg   (cfg_ff),
      .gest  (gest)
   );

endmodule

`default_nettype wire

// File: rtl/tgm_checker.sv
// port checker for the tilt gesture unit and its bind
`default_nettype none

module tgm_checker (
   input wire              clock,
   input wire              reset,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input tgm_pkg::rsp_type rsp_data
);
   import tgm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_move_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.move_valid |-> rsp_data.move_dx == 8'sd0
                                            && rsp_data.move_dy == 8'sd0)
      else $error("cursor delta without move");

   a_click_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.right_click || rsp_data.left_click) |->
         !(rsp_data.right_click && rsp_data.left_click) && !rsp_data.alt_tab
         && !rsp_data.release_buttons)
      else $error("click start together with a conflicting event");

   a_zoom_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.zoom_in && rsp_data.zoom_out))
      else $error("zoom in and zoom out together");

endmodule

bind tilt_gesture_to_mouse_events_unit tgm_checker u_checker (.*);

`default_nettype wire
